// ----- rtl/load_store_instruction_executor_assert.svh -----
// Assertion macros for the load/store instruction executor.
`ifndef LOAD_STORE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define LOAD_STORE_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define LSIE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsie: property violated");

// Check that a condition never holds outside reset.
`define LSIE_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lsie: forbidden condition seen");

`else

`define LSIE_ASSERT(lbl, clk, rst_n, prop)
`define LSIE_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/lsie_pkg.sv -----
// Shared types and constants of the load/store instruction executor.
`default_nettype none

package lsie_pkg;

    localparam int REG_COUNT_DEF  = 32;
    localparam int DATA_WORDS_DEF = 4096;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OP_W        = 4;
    localparam int REG_FIELD_W = 5;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;

    localparam int RESET_WORD  = 777;

    typedef enum logic [OP_W-1:0] {
        OP_MOVC  = 4'd0,
        OP_ADD   = 4'd1,
        OP_ADDL  = 4'd2,
        OP_SUB   = 4'd3,
        OP_SUBL  = 4'd4,
        OP_MUL   = 4'd5,
        OP_AND   = 4'd6,
        OP_OR    = 4'd7,
        OP_XOR   = 4'd8,
        OP_LOAD  = 4'd9,
        OP_LDR   = 4'd10,
        OP_STORE = 4'd11,
        OP_STR   = 4'd12,
        OP_JUMP  = 4'd13,
        OP_HALT  = 4'd14,
        OP_NOP   = 4'd15
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ADDR = 2'd1,
        ST_HALT = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/lsie_in_if.sv -----
// Instruction request channel of the load/store instruction executor.
`default_nettype none

interface lsie_in_if import lsie_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               operation;
    logic [REG_FIELD_W-1:0]        dest_reg;
    logic [REG_FIELD_W-1:0]        src1_reg;
    logic [REG_FIELD_W-1:0]        src2_reg;
    logic [REG_FIELD_W-1:0]        src3_reg;
    logic signed [VALUE_W-1:0]     immediate;

    modport source (
        output valid, operation, dest_reg, src1_reg, src2_reg, src3_reg, immediate,
        input  ready
    );

    modport sink (
        input  valid, operation, dest_reg, src1_reg, src2_reg, src3_reg, immediate,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/lsie_out_if.sv -----
// Result request channel of the load/store instruction executor.
`default_nettype none

interface lsie_out_if import lsie_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic [STATUS_W-1:0]           status;
    logic                          reg_written;
    logic [REG_FIELD_W-1:0]        written_reg;
    logic signed [VALUE_W-1:0]     written_value;
    logic                          jump_taken;
    logic signed [VALUE_W-1:0]     jump_target;

    modport source (
        output valid, status, reg_written, written_reg, written_value,
               jump_taken, jump_target,
        input  ready
    );

    modport sink (
        input  valid, status, reg_written, written_reg, written_value,
               jump_taken, jump_target,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/lsie_regfile.sv -----
// Register file: two registered read ports, one write port, write-first bypass.
`default_nettype none

module lsie_regfile import lsie_pkg::*; #(
    parameter int REG_COUNT  = REG_COUNT_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    localparam int RIW = $clog2(REG_COUNT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [RIW-1:0]        i_rd_addr_a,
    input  logic [RIW-1:0]        i_rd_addr_b,
    input  logic                  i_wr_en,
    input  logic [RIW-1:0]        i_wr_addr,
    input  logic [WORD_WIDTH-1:0] i_wr_data,
    output logic [WORD_WIDTH-1:0] o_rd_a,
    output logic [WORD_WIDTH-1:0] o_rd_b
);

    logic [WORD_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_vld;
    logic [WORD_WIDTH-1:0] r_rd_a;
    logic [WORD_WIDTH-1:0] r_rd_b;
    logic [WORD_WIDTH-1:0] r_fwd;
    logic                  r_fa;
    logic                  r_fb;
    logic                  r_va;
    logic                  r_vb;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
            r_fwd  <= i_wr_data;
        end
    end

    // Entries never written read as zero; a write in the read cycle wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_fa  <= 1'b0;
            r_fb  <= 1'b0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fa <= i_wr_en && (i_wr_addr == i_rd_addr_a);
                r_fb <= i_wr_en && (i_wr_addr == i_rd_addr_b);
                r_va <= r_vld[i_rd_addr_a];
                r_vb <= r_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_a = r_fa ? r_fwd : (r_va ? r_rd_a : '0);
    assign o_rd_b = r_fb ? r_fwd : (r_vb ? r_rd_b : '0);

endmodule

`default_nettype wire

// ----- rtl/lsie_dstore.sv -----
// Data store: one write port, one registered read port, reset fill sweep.
`default_nettype none

module lsie_dstore import lsie_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    localparam int AW = $clog2(DATA_WORDS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [WORD_WIDTH-1:0] o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [WORD_WIDTH-1:0] i_wr_data,
    output logic                  o_busy
);

    logic [WORD_WIDTH-1:0] r_mem [DATA_WORDS];
    logic [WORD_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         r_clr_cnt;
    logic                  r_busy;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [WORD_WIDTH-1:0] wd;

    // Sweep every word to the reset pattern after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(DATA_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign we = r_busy || i_wr_en;
    assign wa = r_busy ? r_clr_cnt : i_wr_addr;
    assign wd = r_busy ? WORD_WIDTH'(RESET_WORD) : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

// ----- rtl/load_store_instruction_executor.sv -----
// Top level of the load/store instruction executor.
// The block executes one decoded instruction per request and returns one result per
// instruction, in order. It accepts a new instruction only while execute is empty
// and the memory stage is empty or draining; a result passes execute and memory into
// the output register and waits there while the next instruction is already taken.
// This limit comes from the register file: its read ports serve the first two sources
// at acceptance, and port b is read again in execute for the index register of a
// register-register store; the write-back of one instruction lands in the cycle the
// next one reads. After reset the data store runs a fill sweep over all DATA_WORDS
// words (4096 by default) that sets every word to 777; no instruction is accepted
// during the sweep. Register indexes are reduced modulo REG_COUNT. An out-of-range
// data address reports status 1 and suppresses the access. Halt reports status 2, and
// every later instruction reports status 2 and changes nothing until the next reset.
`default_nettype none
`include "load_store_instruction_executor_assert.svh"

module load_store_instruction_executor import lsie_pkg::*; #(
    parameter int REG_COUNT  = REG_COUNT_DEF,
    parameter int DATA_WORDS = DATA_WORDS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsie_in_if.sink     i_in,
    lsie_out_if.source  o_out
);

    localparam int W   = WORD_WIDTH;
    localparam int RIW = $clog2(REG_COUNT);
    localparam int AW  = $clog2(DATA_WORDS);
    localparam int HW  = (W + 1) / 2;
    localparam int CW  = (W > 17) ? W : 17;
    localparam int RCW = REG_FIELD_W + 2;

    // Reduce a register field modulo REG_COUNT by repeated subtraction.
    function automatic logic [RIW-1:0] f_reg_idx(input logic [REG_FIELD_W-1:0] field);
        logic [RCW-1:0] v;
        v = RCW'(field);
        for (int k = 0; k < 4; k++) begin
            if (v >= RCW'(REG_COUNT)) begin
                v = v - RCW'(REG_COUNT);
            end
        end
        return RIW'(v);
    endfunction

    // An address word is in range when non-negative and below DATA_WORDS.
    function automatic logic f_addr_ok(input logic [W-1:0] addr);
        return !addr[W-1] && (CW'(addr) < CW'(DATA_WORDS));
    endfunction

    // Handshake
    logic          accept;
    logic          in_ready;
    logic          m_done;
    logic          ds_busy;

    // Register file port
    logic          rf_rd_en;
    logic [RIW-1:0] rf_rd_addr_b;
    logic          rf_wr_en;
    logic [W-1:0]  rf_a;
    logic [W-1:0]  rf_b;

    // Data store port
    logic          ds_rd_en;
    logic [W-1:0]  ds_rd_data;
    logic          ds_wr_en;

    // Execute stage registers
    logic          r_e_valid;
    t_op           r_e_op;
    logic [RIW-1:0] r_e_dest;
    logic [RIW-1:0] r_e_s3;
    logic [W-1:0]  r_e_imm;
    logic          r_halted;

    // Execute stage logic
    logic [W-1:0]  e_alu;
    logic [W-1:0]  e_ld_addr;
    logic          e_ld_ok;
    logic          e_is_load;
    logic [HW-1:0] e_a_lo;
    logic [HW-1:0] e_b_lo;
    logic [W-HW-1:0] e_a_hi;
    logic [W-HW-1:0] e_b_hi;
    logic [2*HW-1:0] e_p0;
    logic [W-1:0]  e_p1;
    logic [W-1:0]  e_p2;

    // Memory stage registers
    logic          r_m_valid;
    t_op           r_m_op;
    logic          r_m_halt;
    logic [RIW-1:0] r_m_dest;
    logic [W-1:0]  r_m_val;
    logic [W-1:0]  r_m_base;
    logic [W-1:0]  r_m_imm;
    logic          r_m_ld_ok;
    logic [2*HW-1:0] r_m_p0;
    logic [W-1:0]  r_m_p1;
    logic [W-1:0]  r_m_p2;

    // Memory stage logic
    logic [W-1:0]  m_st_addr;
    logic          m_st_ok;
    logic [W-1:0]  m_mul;
    logic [W-1:0]  m_val;
    logic          m_wr;
    logic          m_st;
    logic          m_jump;
    t_status       m_status;

    // Output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_wr;
    logic [REG_FIELD_W-1:0] r_out_reg;
    logic [VALUE_W-1:0] r_out_val;
    logic               r_out_jump;
    logic [VALUE_W-1:0] r_out_target;

    // Take a request only outside the fill sweep, with execute empty and the memory stage able to drain.
    assign m_done   = r_m_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !ds_busy && !r_e_valid && (!r_m_valid || m_done);
    assign accept   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Read sources at acceptance; reread port b for the store index in the cycle after.
    assign rf_rd_en     = accept || r_e_valid;
    assign rf_rd_addr_b = accept ? f_reg_idx(i_in.src2_reg) : r_e_s3;

    lsie_regfile #(
        .REG_COUNT  (REG_COUNT),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rf_rd_en),
        .i_rd_addr_a (f_reg_idx(i_in.src1_reg)),
        .i_rd_addr_b (rf_rd_addr_b),
        .i_wr_en     (rf_wr_en),
        .i_wr_addr   (r_m_dest),
        .i_wr_data   (m_val),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_op   <= t_op'(i_in.operation);
            r_e_dest <= f_reg_idx(i_in.dest_reg);
            r_e_s3   <= f_reg_idx(i_in.src3_reg);
            r_e_imm  <= W'(i_in.immediate);
        end
    end

    // Execute: ALU, load address and check, partial products of the multiply.
    assign e_is_load = (r_e_op == OP_LOAD) || (r_e_op == OP_LDR);
    assign e_ld_addr = rf_a + ((r_e_op == OP_LOAD) ? r_e_imm : rf_b);
    assign e_ld_ok   = f_addr_ok(e_ld_addr);

    always_comb begin
        case (r_e_op)
            OP_MOVC:  e_alu = r_e_imm;
            OP_ADD:   e_alu = rf_a + rf_b;
            OP_ADDL:  e_alu = rf_a + r_e_imm;
            OP_SUB:   e_alu = rf_a - rf_b;
            OP_SUBL:  e_alu = rf_a - r_e_imm;
            OP_AND:   e_alu = rf_a & rf_b;
            OP_OR:    e_alu = rf_a | rf_b;
            OP_XOR:   e_alu = rf_a ^ rf_b;
            OP_JUMP:  e_alu = rf_a + r_e_imm;
            OP_STORE: e_alu = rf_a;
            OP_STR:   e_alu = rf_a;
            default:  e_alu = '0;
        endcase
    end

    assign e_a_lo = rf_a[HW-1:0];
    assign e_b_lo = rf_b[HW-1:0];
    assign e_a_hi = rf_a[W-1:HW];
    assign e_b_hi = rf_b[W-1:HW];
    assign e_p0   = (2*HW)'(e_a_lo) * (2*HW)'(e_b_lo);
    assign e_p1   = W'(e_a_lo * e_b_hi);
    assign e_p2   = W'(e_a_hi * e_b_lo);

    // Halt freezes from the next instruction on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
        end else if (r_e_valid && !r_halted && (r_e_op == OP_HALT)) begin
            r_halted <= 1'b1;
        end
    end

    assign ds_rd_en = r_e_valid && !r_halted && e_is_load && e_ld_ok;

    // Execute always advances: the memory stage is empty whenever execute is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_e_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_done) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e_valid) begin
            r_m_op    <= r_e_op;
            r_m_halt  <= r_halted;
            r_m_dest  <= r_e_dest;
            r_m_val   <= e_alu;
            r_m_base  <= rf_b;
            r_m_imm   <= r_e_imm;
            r_m_ld_ok <= e_ld_ok;
            r_m_p0    <= e_p0;
            r_m_p1    <= e_p1;
            r_m_p2    <= e_p2;
        end
    end

    // Memory stage: store address from base plus offset or index register.
    assign m_st_addr = r_m_base + ((r_m_op == OP_STORE) ? r_m_imm : rf_b);
    assign m_st_ok   = f_addr_ok(m_st_addr);
    assign m_mul     = W'(r_m_p0) + ((r_m_p1 + r_m_p2) << HW);

    always_comb begin
        m_val    = '0;
        m_wr     = 1'b0;
        m_st     = 1'b0;
        m_jump   = 1'b0;
        m_status = ST_OK;
        if (r_m_halt) begin
            m_status = ST_HALT;
        end else begin
            case (r_m_op)
                OP_MOVC, OP_ADD, OP_ADDL, OP_SUB, OP_SUBL,
                OP_AND, OP_OR, OP_XOR: begin
                    m_val = r_m_val;
                    m_wr  = 1'b1;
                end
                OP_MUL: begin
                    m_val = m_mul;
                    m_wr  = 1'b1;
                end
                OP_LOAD, OP_LDR: begin
                    if (r_m_ld_ok) begin
                        m_val = ds_rd_data;
                        m_wr  = 1'b1;
                    end else begin
                        m_status = ST_ADDR;
                    end
                end
                OP_STORE, OP_STR: begin
                    if (m_st_ok) begin
                        m_st = 1'b1;
                    end else begin
                        m_status = ST_ADDR;
                    end
                end
                OP_JUMP: begin
                    m_jump = 1'b1;
                end
                OP_HALT: begin
                    m_status = ST_HALT;
                end
                default: begin
                end
            endcase
        end
    end

    // Commit register and store writes once, when the result moves out.
    assign rf_wr_en = m_done && m_wr;
    assign ds_wr_en = m_done && m_st;

    lsie_dstore #(
        .DATA_WORDS (DATA_WORDS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ds_rd_en),
        .i_rd_addr (e_ld_addr[AW-1:0]),
        .o_rd_data (ds_rd_data),
        .i_wr_en   (ds_wr_en),
        .i_wr_addr (m_st_addr[AW-1:0]),
        .i_wr_data (r_m_val),
        .o_busy    (ds_busy)
    );

    // Output register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (m_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_done) begin
            r_out_status <= m_status;
            r_out_wr     <= m_wr;
            r_out_reg    <= m_wr ? REG_FIELD_W'(r_m_dest) : '0;
            r_out_val    <= VALUE_W'(m_val);
            r_out_jump   <= m_jump;
            r_out_target <= m_jump ? VALUE_W'(r_m_val) : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.reg_written   = r_out_wr;
    assign o_out.written_reg   = r_out_reg;
    assign o_out.written_value = r_out_val;
    assign o_out.jump_taken    = r_out_jump;
    assign o_out.jump_target   = r_out_target;

    `LSIE_ASSERT(a_exec_m_empty, i_clk, i_rst_n, r_e_valid |-> !r_m_valid)
    `LSIE_ASSERT(a_accept_exec, i_clk, i_rst_n, accept |=> r_e_valid)
    `LSIE_NEVER(a_no_accept_fill, i_clk, i_rst_n, ds_busy && accept)
    `LSIE_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_halted |=> r_halted)
    `LSIE_NEVER(a_halt_frozen, i_clk, i_rst_n, r_halted && (rf_wr_en || ds_wr_en))

endmodule

`default_nettype wire
